/* sv/pfa_pkg.sv */
// Shared constants and types for the paged frame allocator.
package pfa_pkg;

	// Geometry of the store and the page tables.
	localparam int FRAME_BITS  = 10;
	localparam int OFFSET_BITS = 10;
	localparam int PROCESSES   = 8;
	localparam int PROC_BITS   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int NFRAMES     = 1 << FRAME_BITS;
	localparam int STORE_BITS  = FRAME_BITS + OFFSET_BITS;
	localparam int PM_BITS     = PROC_BITS + FRAME_BITS;
	localparam int CLR_BITS    = (STORE_BITS > PM_BITS) ? STORE_BITS : PM_BITS;

	// Field widths of the request and result.
	localparam int PID_W   = 4;
	localparam int SIZE_W  = 21;
	localparam int ADDR_W  = 20;
	localparam int DATA_W  = 8;
	localparam int PAGES_W = SIZE_W - OFFSET_BITS + 1;
	localparam int FF_W    = FRAME_BITS + 1;
	localparam int LINK_W  = FRAME_BITS + 1;
	localparam int PME_W   = FRAME_BITS + 1;
	localparam int SUM_W   = STORE_BITS + 3;

	// Request types.
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_WRITE = 2'd3;

	// Latched request.
	typedef struct packed {
		logic [1:0]           rtype;
		logic [PID_W-1:0]     pid;
		logic [PROC_BITS-1:0] proc;
		logic [SIZE_W-1:0]    size;
		logic [ADDR_W-1:0]    addr;
		logic [DATA_W-1:0]    wdata;
	} req_t;

endpackage

/* sv/paged_frame_allocator_mmu.sv */
// Top level of the paged frame allocator: request sequencer over four RAMs.
//
//  channel  dir  handshake          contents
//  s_       in   tvalid / tready    tuser: req_type; tdata: pid, size, address, write_data
//  m_       out  tvalid / tready    tdata: status, alloc_address, read_data
//
// After reset a clearing pass zeroes the store, owner and page tables, one
// entry a cycle; no request is taken until the pass ends.
// A read steps through S_LOOK, S_TRANS and S_RDATA, a write through S_LOOK
// and S_TRANS. Allocate scans the owner RAM one frame a cycle. Free walks the
// frame chain, reading owner and link RAM in S_WRD and S_WCHK per frame, then unmaps
// one page a cycle. A new request is taken while a finished result waits on the output.
module paged_frame_allocator_mmu
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	input  logic [55:0] s_tdata,  // [3:0] process_id, [24:4] size, [44:25] address,
	                              // [52:45] write_data, [55:53] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [0] status, [20:1] alloc_address, [28:21] read_data,
	                              // [31:29] zero
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LOOK  = 4'd2;
	localparam logic [3:0] S_TRANS = 4'd3;
	localparam logic [3:0] S_RDATA = 4'd4;
	localparam logic [3:0] S_ASCAN = 4'd5;
	localparam logic [3:0] S_AEND  = 4'd6;
	localparam logic [3:0] S_WRD   = 4'd7;
	localparam logic [3:0] S_WCHK  = 4'd8;
	localparam logic [3:0] S_UNMAP = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]            state_q;
	logic [CLR_BITS-1:0]   clr_q;
	req_t                  req_q;
	logic                  pid_ok_q;
	logic [STORE_BITS-1:0] bp_q [PROCESSES];
	logic [FF_W-1:0]       ff_q;
	logic [PAGES_W-1:0]    pages_q;
	logic [FF_W-1:0]       taken_q;
	logic [FF_W-1:0]       f_q;
	logic [FRAME_BITS-1:0] f_s1;
	logic                  vld_s1;
	logic [FRAME_BITS-1:0] last_q;
	logic [FRAME_BITS-1:0] wf_q;
	logic [FF_W-1:0]       walk_n_q;
	logic [FF_W-1:0]       i_q;
	logic                  res_status_q;
	logic [ADDR_W-1:0]     res_aaddr_q;
	logic [DATA_W-1:0]     res_rdata_q;
	logic                  out_valid_q;
	logic [28:0]           out_data_q;

	// RAM ports.
	logic                  own_we, lk_we, pm_we, st_we;
	logic [FRAME_BITS-1:0] own_waddr, own_raddr, lk_waddr, lk_raddr;
	logic [PID_W-1:0]      own_wdata, own_rdata;
	logic [LINK_W-1:0]     lk_wdata, lk_rdata;
	logic [PM_BITS-1:0]    pm_waddr, pm_raddr;
	logic [PME_W-1:0]      pm_wdata, pm_rdata;
	logic [STORE_BITS-1:0] st_waddr, st_raddr;
	logic [DATA_W-1:0]     st_wdata, st_rdata;

	// Derived values for the current request.
	logic [STORE_BITS-1:0] bp_cur;
	logic [FRAME_BITS-1:0] vp0_alloc, vp_addr;
	logic [PAGES_W-1:0]    pages_c;
	logic [SUM_W-1:0]      bp_sum;
	logic                  claim;
	logic [FF_W-1:0]       unmap_vp;
	logic [STORE_BITS:0]   walk_bytes;
	logic                  out_free;
	logic [PID_W-1:0]      in_pid;

	assign in_pid     = s_tdata[3:0];
	assign bp_cur     = bp_q[req_q.proc];
	assign vp0_alloc  = bp_cur[STORE_BITS-1:OFFSET_BITS];
	assign vp_addr    = req_q.addr[STORE_BITS-1:OFFSET_BITS];
	assign pages_c    = PAGES_W'(({1'b0, req_q.size} + (SIZE_W+1)'((1 << OFFSET_BITS) - 1))
	                    >> OFFSET_BITS);
	assign bp_sum     = SUM_W'(bp_cur) + SUM_W'({pages_q, {OFFSET_BITS{1'b0}}});
	assign claim      = (state_q == S_ASCAN) && vld_s1 && (own_rdata == '0);
	assign unmap_vp   = FF_W'(vp_addr) + i_q;
	assign walk_bytes = (STORE_BITS+1)'({walk_n_q, {OFFSET_BITS{1'b0}}});
	assign out_free   = !out_valid_q || m_tready;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_data_q};

	// Memory port selection.
	always_comb begin
		own_we    = 1'b0;
		own_waddr = wf_q;
		own_wdata = '0;
		own_raddr = (state_q == S_ASCAN) ? f_q[FRAME_BITS-1:0] : wf_q;
		lk_we     = 1'b0;
		lk_waddr  = last_q;
		lk_wdata  = LINK_W'(f_s1);
		lk_raddr  = wf_q;
		pm_we     = 1'b0;
		pm_waddr  = {req_q.proc, unmap_vp[FRAME_BITS-1:0]};
		pm_wdata  = '0;
		pm_raddr  = {req_q.proc, vp_addr};
		st_we     = 1'b0;
		st_waddr  = {pm_rdata[FRAME_BITS-1:0], req_q.addr[OFFSET_BITS-1:0]};
		st_wdata  = req_q.wdata;
		st_raddr  = {pm_rdata[FRAME_BITS-1:0], req_q.addr[OFFSET_BITS-1:0]};
		case (state_q)
			S_CLEAR: begin
				own_we    = 1'b1;
				own_waddr = clr_q[FRAME_BITS-1:0];
				pm_we     = 1'b1;
				pm_waddr  = clr_q[PM_BITS-1:0];
				st_we     = 1'b1;
				st_waddr  = clr_q[STORE_BITS-1:0];
				st_wdata  = '0;
			end
			S_ASCAN: begin
				if (claim) begin
					own_we    = 1'b1;
					own_waddr = f_s1;
					own_wdata = req_q.pid;
					pm_we     = 1'b1;
					pm_waddr  = {req_q.proc, FRAME_BITS'(vp0_alloc + taken_q[FRAME_BITS-1:0])};
					pm_wdata  = {1'b1, f_s1};
					lk_we     = (taken_q != '0);
				end
			end
			S_AEND: begin
				lk_we    = 1'b1;
				lk_wdata = LINK_W'(1) << FRAME_BITS;
			end
			S_TRANS: begin
				st_we = (req_q.rtype == REQ_WRITE) && pm_rdata[FRAME_BITS];
			end
			S_WCHK: begin
				own_we = (own_rdata != '0);
			end
			S_UNMAP: begin
				pm_we = (i_q < walk_n_q) && !unmap_vp[FRAME_BITS];
			end
			default: begin
			end
		endcase
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			ff_q         <= FF_W'(NFRAMES);
			out_valid_q  <= 1'b0;
			pid_ok_q     <= 1'b0;
			vld_s1       <= 1'b0;
			for (int p = 0; p < PROCESSES; p++) begin
				bp_q[p] <= STORE_BITS'(1 << OFFSET_BITS);
			end
		end else begin
			// The output register loads a finished result or empties when taken.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						req_q.rtype  <= s_tuser;
						req_q.pid    <= in_pid;
						req_q.proc   <= PROC_BITS'(in_pid - 1'b1);
						req_q.size   <= s_tdata[24:4];
						req_q.addr   <= s_tdata[44:25];
						req_q.wdata  <= s_tdata[52:45];
						pid_ok_q     <= (in_pid != '0) && (in_pid <= PID_W'(PROCESSES));
						res_status_q <= 1'b1;
						res_aaddr_q  <= '0;
						res_rdata_q  <= '0;
						state_q      <= S_LOOK;
					end
				end
				S_LOOK: begin
					pages_q <= pages_c;
					if (!pid_ok_q) begin
						state_q <= S_DONE;
					end else if (req_q.rtype == REQ_ALLOC) begin
						f_q     <= '0;
						vld_s1  <= 1'b0;
						taken_q <= '0;
						if (pages_c == '0) begin
							res_status_q <= 1'b0;
							res_aaddr_q  <= ADDR_W'(bp_cur);
							state_q      <= S_DONE;
						end else begin
							state_q <= S_ASCAN;
						end
					end else begin
						state_q <= S_TRANS;
					end
				end
				S_ASCAN: begin
					// Check room on the first scan cycle, before any frame is claimed.
					if (!vld_s1 && f_q == '0 &&
					    (({1'b0, ff_q} < pages_q) || bp_sum[SUM_W-1:STORE_BITS] != '0)) begin
						state_q <= S_DONE;
					end else begin
						vld_s1 <= (f_q < FF_W'(NFRAMES));
						f_s1   <= f_q[FRAME_BITS-1:0];
						if (f_q < FF_W'(NFRAMES)) begin
							f_q <= f_q + 1'b1;
						end
						if (claim) begin
							last_q  <= f_s1;
							taken_q <= taken_q + 1'b1;
							ff_q    <= ff_q - 1'b1;
							if (PAGES_W'(taken_q + 1'b1) == pages_q) begin
								state_q <= S_AEND;
							end
						end
					end
				end
				S_AEND: begin
					bp_q[req_q.proc] <= bp_sum[STORE_BITS-1:0];
					res_status_q     <= 1'b0;
					res_aaddr_q      <= ADDR_W'(bp_cur);
					state_q          <= S_DONE;
				end
				S_TRANS: begin
					if (!pm_rdata[FRAME_BITS]) begin
						state_q <= S_DONE;
					end else begin
						case (req_q.rtype)
							REQ_READ: begin
								state_q <= S_RDATA;
							end
							REQ_WRITE: begin
								res_status_q <= 1'b0;
								state_q      <= S_DONE;
							end
							default: begin
								wf_q     <= pm_rdata[FRAME_BITS-1:0];
								walk_n_q <= '0;
								state_q  <= S_WRD;
							end
						endcase
					end
				end
				S_RDATA: begin
					res_rdata_q  <= st_rdata;
					res_status_q <= 1'b0;
					state_q      <= S_DONE;
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (own_rdata != '0) begin
						ff_q <= ff_q + 1'b1;
					end
					walk_n_q <= walk_n_q + 1'b1;
					i_q      <= '0;
					if (lk_rdata[FRAME_BITS] || (walk_n_q + 1'b1) == FF_W'(NFRAMES)) begin
						state_q <= S_UNMAP;
					end else begin
						wf_q    <= lk_rdata[FRAME_BITS-1:0];
						state_q <= S_WRD;
					end
				end
				S_UNMAP: begin
					if ((i_q < walk_n_q) && !unmap_vp[FRAME_BITS]) begin
						i_q <= i_q + 1'b1;
					end else begin
						if ({1'b0, bp_cur} >= walk_bytes) begin
							bp_q[req_q.proc] <= STORE_BITS'({1'b0, bp_cur} - walk_bytes);
						end else begin
							bp_q[req_q.proc] <= '0;
						end
						res_status_q <= 1'b0;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q  <= {res_rdata_q, res_aaddr_q, res_status_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Frame owner table.
	pfa_ram #(.WIDTH(PID_W), .DEPTH(NFRAMES)) u_owner (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(own_raddr), .rdata(own_rdata)
	);

	// Frame chain links.
	pfa_ram #(.WIDTH(LINK_W), .DEPTH(NFRAMES)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.raddr(lk_raddr), .rdata(lk_rdata)
	);

	// Per-process page maps.
	pfa_ram #(.WIDTH(PME_W), .DEPTH(1 << PM_BITS)) u_pmap (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rdata)
	);

	// Byte store.
	pfa_ram #(.WIDTH(DATA_W), .DEPTH(1 << STORE_BITS)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// The free count never exceeds the number of frames.
	a_ff_range: assert property (@(posedge clk) disable iff (!arst_n)
		ff_q <= FF_W'(NFRAMES)) else $error("free frame count out of range");

	// A scan never claims more frames than were requested.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN && vld_s1) |-> (PAGES_W'(taken_q) < pages_q))
		else $error("allocation scan overran its page count");

	// The chain walk stops within the frame count.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCHK) |-> (walk_n_q < FF_W'(NFRAMES)))
		else $error("chain walk overran");

	// A failed request returns zero fields.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[0]) |-> (out_data_q[28:1] == '0))
		else $error("failure result carries data");

endmodule

/* sv/pfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
